// ----- rtl/sliding_window_peak_rate_assert.svh -----
// Assertion macros for the sliding window peak rate block
`ifndef SLIDING_WINDOW_PEAK_RATE_ASSERT_SVH
`define SLIDING_WINDOW_PEAK_RATE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held
`define SWPR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("swpr assertion failed");

// Next-cycle implication, disabled while reset is held
`define SWPR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("swpr assertion failed");

`endif

// ----- rtl/swpr_pkg.sv -----
// Shared types and constants of the sliding window peak rate block
package swpr_pkg;

    localparam int RING_DEPTH = 1024;
    localparam int RING_AW    = $clog2(RING_DEPTH);
    localparam int CNT_W      = RING_AW + 1;

    localparam int TS_W       = 22;
    localparam int DAY_W      = 5;
    localparam int HOUR_W     = 5;
    localparam int MIN_W      = 6;
    localparam int SEC_W      = 6;
    localparam int STATUS_W   = 10;
    localparam int CNT_OUT_W  = 11;
    localparam int ERR_W      = 16;

    localparam int MUL_A_W    = 6;
    localparam int WEIGHT_W   = 17;
    localparam int PROD_W     = MUL_A_W + WEIGHT_W;

    localparam int SEC_PER_MIN  = 60;
    localparam int MIN_PER_HOUR = 60;
    localparam int HOUR_PER_DAY = 24;
    localparam int SEC_PER_HOUR = SEC_PER_MIN * MIN_PER_HOUR;
    localparam int SEC_PER_DAY  = SEC_PER_HOUR * HOUR_PER_DAY;

    localparam logic [WEIGHT_W-1:0] W_DAY  = WEIGHT_W'(SEC_PER_DAY);
    localparam logic [WEIGHT_W-1:0] W_HOUR = WEIGHT_W'(SEC_PER_HOUR);
    localparam logic [WEIGHT_W-1:0] W_MIN  = WEIGHT_W'(SEC_PER_MIN);
    localparam logic [WEIGHT_W-1:0] W_SEC  = WEIGHT_W'(1);

    localparam logic [STATUS_W-1:0] STATUS_ERR_LO = STATUS_W'(500);
    localparam logic [STATUS_W-1:0] STATUS_ERR_HI = STATUS_W'(599);

    localparam logic [ERR_W-1:0]  ERR_MAX       = {ERR_W{1'b1}};
    localparam logic [TS_W-1:0]   WINDOW_RESET  = TS_W'(60);
    localparam logic [CNT_W-1:0]  DEPTH_CNT     = CNT_W'(RING_DEPTH);
    localparam logic [CNT_W-1:0]  DEPTH_CNT_M1  = CNT_W'(RING_DEPTH - 1);

    typedef struct packed {
        logic [DAY_W-1:0]  day;
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0]  minute;
        logic [SEC_W-1:0]  second;
    } t_time;

    typedef struct packed {
        logic [CNT_OUT_W-1:0] window_count;
        logic [CNT_OUT_W-1:0] peak_count;
        logic [ERR_W-1:0]     error_count;
        logic                 ring_overflowed;
    } t_result;

    typedef struct packed {
        logic            wr_en;
        logic [RING_AW-1:0] wr_addr;
        logic [TS_W-1:0] wr_data;
        logic [RING_AW-1:0] rd_addr;
    } t_ring_req;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DAY,
        ST_HOUR,
        ST_MIN,
        ST_SEC
    } t_stamp_state;

    typedef enum logic [2:0] {
        S_IDLE,
        S_STAMP,
        S_PUSH,
        S_READ,
        S_CMP,
        S_FIN
    } t_ctrl_state;

endpackage

// ----- rtl/swpr_ram.sv -----
// Generic single write port, single read port RAM with registered read
module swpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/swpr_stamp.sv -----
// Time to absolute second count, one multiply-accumulate per cycle
module swpr_stamp (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  swpr_pkg::t_time           i_time,
    output logic                      o_done,
    output logic [swpr_pkg::TS_W-1:0] o_stamp
);

    swpr_pkg::t_stamp_state r_state, n_state;
    swpr_pkg::t_time        r_time;
    logic [swpr_pkg::TS_W-1:0]     r_acc, n_acc;
    logic                          r_done, n_done;
    logic [swpr_pkg::MUL_A_W-1:0]  mul_a;
    logic [swpr_pkg::WEIGHT_W-1:0] mul_b;
    logic [swpr_pkg::PROD_W-1:0]   prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= swpr_pkg::ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        if (i_start && (r_state == swpr_pkg::ST_IDLE)) begin
            r_time <= i_time;
        end
    end

    assign prod = swpr_pkg::PROD_W'(mul_a) * swpr_pkg::PROD_W'(mul_b);

    always_comb begin
        n_state = r_state;
        n_acc   = r_acc + swpr_pkg::TS_W'(prod);
        n_done  = 1'b0;
        mul_a   = '0;
        mul_b   = '0;
        unique case (r_state)
            swpr_pkg::ST_IDLE: begin
                n_acc = r_acc;
                if (i_start) begin
                    n_acc   = '0;
                    n_state = swpr_pkg::ST_DAY;
                end
            end
            swpr_pkg::ST_DAY: begin
                mul_a   = swpr_pkg::MUL_A_W'(r_time.day);
                mul_b   = swpr_pkg::W_DAY;
                n_state = swpr_pkg::ST_HOUR;
            end
            swpr_pkg::ST_HOUR: begin
                mul_a   = swpr_pkg::MUL_A_W'(r_time.hour);
                mul_b   = swpr_pkg::W_HOUR;
                n_state = swpr_pkg::ST_MIN;
            end
            swpr_pkg::ST_MIN: begin
                mul_a   = swpr_pkg::MUL_A_W'(r_time.minute);
                mul_b   = swpr_pkg::W_MIN;
                n_state = swpr_pkg::ST_SEC;
            end
            swpr_pkg::ST_SEC: begin
                mul_a   = swpr_pkg::MUL_A_W'(r_time.second);
                mul_b   = swpr_pkg::W_SEC;
                n_state = swpr_pkg::ST_IDLE;
                n_done  = 1'b1;
            end
            default: begin
                n_state = swpr_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_done  = r_done;
    assign o_stamp = r_acc;

endmodule

// ----- rtl/swpr_ctrl.sv -----
// Sequencer: push, trim loop with shared compare, peak and result register
module swpr_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [swpr_pkg::STATUS_W-1:0] i_status,
    input  logic                          i_stamp_done,
    input  logic [swpr_pkg::TS_W-1:0]     i_stamp,
    input  logic [swpr_pkg::TS_W-1:0]     i_window,
    input  logic [swpr_pkg::TS_W-1:0]     i_rd_data,
    input  logic                          i_out_stall,
    output swpr_pkg::t_ring_req           o_ring,
    output logic                          o_busy,
    output logic                          o_out_valid,
    output swpr_pkg::t_result             o_result
);

    swpr_pkg::t_ctrl_state r_state, n_state;
    logic [swpr_pkg::RING_AW-1:0]  r_oldest, n_oldest;
    logic [swpr_pkg::CNT_W-1:0]    r_held, n_held;
    logic [swpr_pkg::CNT_W-1:0]    r_peak, n_peak;
    logic [swpr_pkg::ERR_W-1:0]    r_err, n_err;
    logic                          r_ovf, n_ovf;
    logic [swpr_pkg::STATUS_W-1:0] r_status;
    logic                          r_out_valid, n_out_valid;
    swpr_pkg::t_result             r_out, n_out;

    logic [swpr_pkg::RING_AW-1:0]  push_oldest;
    logic [swpr_pkg::CNT_W-1:0]    push_held;
    logic                          push_ovf;
    logic                          is_err;
    logic signed [swpr_pkg::TS_W+1:0] diff;
    logic                          pop;
    logic                          out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= swpr_pkg::S_IDLE;
            r_oldest    <= '0;
            r_held      <= '0;
            r_peak      <= '0;
            r_err       <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_oldest    <= n_oldest;
            r_held      <= n_held;
            r_peak      <= n_peak;
            r_err       <= n_err;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (i_accept) begin
            r_status <= i_status;
        end
    end

    assign is_err = (r_status >= swpr_pkg::STATUS_ERR_LO)
                 && (r_status <= swpr_pkg::STATUS_ERR_HI);

    // time may run backwards: signed difference, negative never pops
    assign diff = $signed({2'b00, i_stamp}) - $signed({2'b00, i_rd_data});
    assign pop  = diff >= $signed({2'b00, i_window});

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        if (r_held >= swpr_pkg::DEPTH_CNT) begin
            push_oldest = r_oldest + swpr_pkg::RING_AW'(1);
            push_held   = swpr_pkg::DEPTH_CNT_M1;
            push_ovf    = 1'b1;
        end else begin
            push_oldest = r_oldest;
            push_held   = r_held;
            push_ovf    = 1'b0;
        end
    end

    always_comb begin
        n_state        = r_state;
        n_oldest       = r_oldest;
        n_held         = r_held;
        n_peak         = r_peak;
        n_err          = r_err;
        n_ovf          = r_ovf;
        n_out          = r_out;
        n_out_valid    = r_out_valid && i_out_stall;
        o_ring.wr_en   = 1'b0;
        o_ring.wr_addr = push_oldest + push_held[swpr_pkg::RING_AW-1:0];
        o_ring.wr_data = i_stamp;
        o_ring.rd_addr = r_oldest;
        unique case (r_state)
            swpr_pkg::S_IDLE: begin
                if (i_accept) begin
                    n_state = swpr_pkg::S_STAMP;
                end
            end
            swpr_pkg::S_STAMP: begin
                if (i_stamp_done) begin
                    n_state = swpr_pkg::S_PUSH;
                end
            end
            swpr_pkg::S_PUSH: begin
                o_ring.wr_en = 1'b1;
                n_oldest     = push_oldest;
                n_held       = push_held + swpr_pkg::CNT_W'(1);
                n_ovf        = push_ovf;
                if (is_err && (r_err != swpr_pkg::ERR_MAX)) begin
                    n_err = r_err + swpr_pkg::ERR_W'(1);
                end
                n_state = swpr_pkg::S_READ;
            end
            swpr_pkg::S_READ: begin
                // newest entry is never popped
                if (r_held > swpr_pkg::CNT_W'(1)) begin
                    n_state = swpr_pkg::S_CMP;
                end else begin
                    n_state = swpr_pkg::S_FIN;
                end
            end
            swpr_pkg::S_CMP: begin
                if (pop) begin
                    n_oldest = r_oldest + swpr_pkg::RING_AW'(1);
                    n_held   = r_held - swpr_pkg::CNT_W'(1);
                    n_state  = swpr_pkg::S_READ;
                end else begin
                    n_state = swpr_pkg::S_FIN;
                end
            end
            swpr_pkg::S_FIN: begin
                if (r_held > r_peak) begin
                    n_peak = r_held;
                end
                if (out_free) begin
                    n_out.window_count    = swpr_pkg::CNT_OUT_W'(r_held);
                    n_out.peak_count      = swpr_pkg::CNT_OUT_W'(n_peak);
                    n_out.error_count     = r_err;
                    n_out.ring_overflowed = r_ovf;
                    n_out_valid           = 1'b1;
                    n_state               = swpr_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = swpr_pkg::S_IDLE;
            end
        endcase
    end

    assign o_busy      = (r_state != swpr_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

endmodule

// ----- rtl/sliding_window_peak_rate.sv -----
// Sliding window peak rate counter: top level
//
// Input channel: i_in_valid / o_in_stall carry one request (day, hour,
// minute, second, status code); a transfer takes place when valid is high
// and stall is low. Output channel: o_out_valid / i_out_stall carry one
// result per request (window count, peak count, error count, overflow flag).
// Configuration: i_cfg_valid / o_cfg_ready write the window length in
// seconds; ready is always high. Write only while the block is idle.
// The time stamp is built by one shared multiply-accumulate over the
// day, hour, minute and second steps, then the trimming loop reads the
// oldest ring entry from the RAM and compares it with one shared
// subtractor, once per entry looked at. The input stalls from the input
// transfer until the result is loaded into the output register and is
// free again in the same cycle that the result appears there.
// A stalled result holds in the output register; a following request is
// taken meanwhile and waits at its last step until the register frees.
// Reset (synchronous, active low) clears all counts and sets the window
// to 60 s; the ring RAM is not cleared, only held entries are ever read.
module sliding_window_peak_rate (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [swpr_pkg::DAY_W-1:0]     i_day_of_month,
    input  logic [swpr_pkg::HOUR_W-1:0]    i_hour_of_day,
    input  logic [swpr_pkg::MIN_W-1:0]     i_minute_of_hour,
    input  logic [swpr_pkg::SEC_W-1:0]     i_second_of_minute,
    input  logic [swpr_pkg::STATUS_W-1:0]  i_status_code,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [swpr_pkg::CNT_OUT_W-1:0] o_window_count,
    output logic [swpr_pkg::CNT_OUT_W-1:0] o_peak_count,
    output logic [swpr_pkg::ERR_W-1:0]     o_error_count,
    output logic                           o_ring_overflowed,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [swpr_pkg::TS_W-1:0]      i_cfg_data
);

    logic [swpr_pkg::TS_W-1:0] r_window;
    logic                      accept;
    logic                      busy;
    swpr_pkg::t_time           in_time;
    logic                      stamp_done;
    logic [swpr_pkg::TS_W-1:0] stamp;
    logic [swpr_pkg::TS_W-1:0] rd_data;
    swpr_pkg::t_ring_req       ring;
    swpr_pkg::t_result         result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= swpr_pkg::WINDOW_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_window <= i_cfg_data;
        end
    end

    assign o_in_stall = busy;
    assign accept     = i_in_valid && !busy;

    assign in_time.day    = i_day_of_month;
    assign in_time.hour   = i_hour_of_day;
    assign in_time.minute = i_minute_of_hour;
    assign in_time.second = i_second_of_minute;

    swpr_stamp u_stamp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_time  (in_time),
        .o_done  (stamp_done),
        .o_stamp (stamp)
    );

    swpr_ram #(
        .WIDTH (swpr_pkg::TS_W),
        .DEPTH (swpr_pkg::RING_DEPTH)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (ring.wr_en),
        .i_wr_addr (ring.wr_addr),
        .i_wr_data (ring.wr_data),
        .i_rd_addr (ring.rd_addr),
        .o_rd_data (rd_data)
    );

    swpr_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_status     (i_status_code),
        .i_stamp_done (stamp_done),
        .i_stamp      (stamp),
        .i_window     (r_window),
        .i_rd_data    (rd_data),
        .i_out_stall  (i_out_stall),
        .o_ring       (ring),
        .o_busy       (busy),
        .o_out_valid  (o_out_valid),
        .o_result     (result)
    );

    assign o_window_count    = result.window_count;
    assign o_peak_count      = result.peak_count;
    assign o_error_count     = result.error_count;
    assign o_ring_overflowed = result.ring_overflowed;

`include "sliding_window_peak_rate_assert.svh"

    `SWPR_ASSERT_NEXT(a_busy_after_transfer, i_clk, i_rst_n, accept, o_in_stall)
    `SWPR_ASSERT_SAME(a_peak_covers_window, i_clk, i_rst_n, o_out_valid, o_peak_count >= o_window_count)
    `SWPR_ASSERT_SAME(a_window_never_empty, i_clk, i_rst_n, o_out_valid, o_window_count != '0)
    `SWPR_ASSERT_SAME(a_no_ring_write_idle, i_clk, i_rst_n, ring.wr_en, busy && !stamp_done)

endmodule

// ----- tb/sv/swpr_window_monitor.sv -----
// Request and result monitor: predicts window, peak, error and overflow outputs and compares them
`timescale 1ns / 100ps
module swpr_window_monitor
    import swpr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  logic [DAY_W-1:0]      i_day_of_month,
    input  logic [HOUR_W-1:0]     i_hour_of_day,
    input  logic [MIN_W-1:0]      i_minute_of_hour,
    input  logic [SEC_W-1:0]      i_second_of_minute,
    input  logic [STATUS_W-1:0]   i_status_code,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  logic [CNT_OUT_W-1:0]  i_window_count,
    input  logic [CNT_OUT_W-1:0]  i_peak_count,
    input  logic [ERR_W-1:0]      i_error_count,
    input  logic                  i_ring_overflowed,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [TS_W-1:0]       i_cfg_data,
    output int                    o_fail_count,
    output int                    o_outstanding,
    output int                    o_overflows,
    output int                    o_peak_seen
);

    localparam int STAMP_MASK      = (1 << TS_W) - 1;
    localparam int ERR_CEIL        = (1 << ERR_W) - 1;
    localparam int SECS_PER_MIN    = 60;
    localparam int SECS_PER_HOUR   = 3600;
    localparam int SECS_PER_DAY    = 86400;
    localparam int SERVER_ERR_LO   = 500;
    localparam int SERVER_ERR_HI   = 599;
    localparam int WINDOW_AT_RESET = 60;

    int      stamp_ring [RING_DEPTH];
    int      oldest_slot = 0;
    int      held        = 0;
    int      peak        = 0;
    int      err_total   = 0;
    int      window_len  = WINDOW_AT_RESET;
    int      mismatches  = 0;
    int      overflows   = 0;
    int      result_no   = 0;
    t_result expected_results [$];

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("%0t ns mismatch: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want) begin
            report_mismatch($sformatf("result %0d %s got %0d want %0d",
                                      result_no, name, got, want));
        end
    endtask

    function automatic t_result predict_request(input int day, input int hour, input int minute,
                                                input int second, input int status);
        int      stamp;
        int      slot;
        logic    dropped;
        t_result res;
        stamp = (second + minute * SECS_PER_MIN + hour * SECS_PER_HOUR + day * SECS_PER_DAY)
                & STAMP_MASK;
        if (status >= SERVER_ERR_LO && status <= SERVER_ERR_HI && err_total < ERR_CEIL) begin
            err_total++;
        end
        dropped = 1'b0;
        if (held >= RING_DEPTH) begin
            oldest_slot = (oldest_slot + 1) % RING_DEPTH;
            held        = RING_DEPTH - 1;
            dropped     = 1'b1;
            overflows++;
        end
        slot = (oldest_slot + held) % RING_DEPTH;
        stamp_ring[slot] = stamp;
        held++;
        // signed difference: a stamp older than the oldest never trims
        while (held > 1 && stamp - stamp_ring[oldest_slot] >= window_len) begin
            oldest_slot = (oldest_slot + 1) % RING_DEPTH;
            held--;
        end
        if (held > peak) begin
            peak = held;
        end
        res.window_count    = CNT_OUT_W'(held);
        res.peak_count      = CNT_OUT_W'(peak);
        res.error_count     = ERR_W'(err_total);
        res.ring_overflowed = dropped;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_result predicted;
        if (!i_rst_n) begin
            oldest_slot = 0;
            held        = 0;
            peak        = 0;
            err_total   = 0;
            window_len  = WINDOW_AT_RESET;
            expected_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                window_len = int'(i_cfg_data);
            end
            if (i_out_valid && !i_out_stall) begin
                result_no++;
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result %0d transfer with no request outstanding",
                                              result_no));
                end else begin
                    predicted = expected_results.pop_front();
                    check_field("window_count", i_window_count, predicted.window_count);
                    check_field("peak_count", i_peak_count, predicted.peak_count);
                    check_field("error_count", i_error_count, predicted.error_count);
                    check_field("ring_overflowed", i_ring_overflowed,
                                predicted.ring_overflowed);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                expected_results.push_back(predict_request(i_day_of_month, i_hour_of_day,
                                                           i_minute_of_hour,
                                                           i_second_of_minute,
                                                           i_status_code));
            end
        end
        o_fail_count  <= mismatches;
        o_outstanding <= expected_results.size();
        o_overflows   <= overflows;
        o_peak_seen   <= peak;
    end

endmodule

// ----- tb/sv/sliding_window_peak_rate_test.sv -----
// Testbench top: request stimulus, window settings and verdict for the peak rate counter
`timescale 1ns / 100ps
module sliding_window_peak_rate_test;

    import swpr_pkg::*;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 16;
    localparam int MAX_WAIT      = 14;
    localparam int SECS_PER_DAY  = 86400;
    localparam int SECS_PER_HOUR = 3600;
    localparam int MONTH_END     = 32 * SECS_PER_DAY;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 in_valid     = 1'b0;
    logic                 in_stall;
    logic [DAY_W-1:0]     day          = '0;
    logic [HOUR_W-1:0]    hour         = '0;
    logic [MIN_W-1:0]     minute       = '0;
    logic [SEC_W-1:0]     second       = '0;
    logic [STATUS_W-1:0]  status       = '0;
    logic                 out_valid;
    logic                 out_stall    = 1'b0;
    logic [CNT_OUT_W-1:0] window_count;
    logic [CNT_OUT_W-1:0] peak_count;
    logic [ERR_W-1:0]     error_count;
    logic                 ring_overflowed;
    logic                 cfg_valid    = 1'b0;
    logic                 cfg_ready;
    logic [TS_W-1:0]      cfg_data     = '0;

    int fail_count;
    int outstanding;
    int overflows;
    int peak_seen;
    int requests_sent = 0;
    int settings_used = 0;
    int cycles        = 0;
    int clock_now     = SECS_PER_DAY;
    int stall_hold    = 0;
    bit steady        = 1'b0;

    sliding_window_peak_rate i_dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .o_in_stall         (in_stall),
        .i_day_of_month     (day),
        .i_hour_of_day      (hour),
        .i_minute_of_hour   (minute),
        .i_second_of_minute (second),
        .i_status_code      (status),
        .o_out_valid        (out_valid),
        .i_out_stall        (out_stall),
        .o_window_count     (window_count),
        .o_peak_count       (peak_count),
        .o_error_count      (error_count),
        .o_ring_overflowed  (ring_overflowed),
        .i_cfg_valid        (cfg_valid),
        .o_cfg_ready        (cfg_ready),
        .i_cfg_data         (cfg_data)
    );

    swpr_window_monitor u_monitor (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .i_in_stall         (in_stall),
        .i_day_of_month     (day),
        .i_hour_of_day      (hour),
        .i_minute_of_hour   (minute),
        .i_second_of_minute (second),
        .i_status_code      (status),
        .i_out_valid        (out_valid),
        .i_out_stall        (out_stall),
        .i_window_count     (window_count),
        .i_peak_count       (peak_count),
        .i_error_count      (error_count),
        .i_ring_overflowed  (ring_overflowed),
        .i_cfg_valid        (cfg_valid),
        .i_cfg_ready        (cfg_ready),
        .i_cfg_data         (cfg_data),
        .o_fail_count       (fail_count),
        .o_outstanding      (outstanding),
        .o_overflows        (overflows),
        .o_peak_seen        (peak_seen)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timed out after %0d cycles, %0d results outstanding", cycles, outstanding);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic int draw_wait();
        return steady ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic int pick_status();
        case ($urandom_range(0, 3))
            0: begin
                return $urandom_range(500, 599);
            end
            1: begin
                return $urandom_range(0, 1023);
            end
            default: begin
                return $urandom_range(200, 404);
            end
        endcase
    endfunction

    // result side: stall for a drawn number of cycles after each transfer
    always @(posedge clk) begin
        if (out_valid && !out_stall) begin
            stall_hold = draw_wait();
            out_stall <= (stall_hold != 0);
        end else if (stall_hold > 0) begin
            stall_hold--;
            out_stall <= (stall_hold != 0);
        end
    end

    task automatic send_request(input int d, input int h, input int m, input int s,
                                input int st);
        int gap;
        gap = draw_wait();
        if ($urandom_range(0, 39) == 0) begin
            steady = !steady;
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        day      <= DAY_W'(d);
        hour     <= HOUR_W'(h);
        minute   <= MIN_W'(m);
        second   <= SEC_W'(s);
        status   <= STATUS_W'(st);
        @(posedge clk);
        while (in_stall) @(posedge clk);
        requests_sent++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_window(input logic [TS_W-1:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // mostly a clock moving forward by random steps; noise is any field value
    task automatic run_phase(input int count, input int max_step, input int noise_pct);
        repeat (count) begin
            if ($urandom_range(0, 99) < noise_pct) begin
                send_request($urandom_range(0, 31), $urandom_range(0, 31),
                             $urandom_range(0, 63), $urandom_range(0, 63),
                             $urandom_range(0, 1023));
            end else begin
                clock_now += $urandom_range(0, max_step);
                if (clock_now >= MONTH_END) begin
                    clock_now = SECS_PER_DAY + $urandom_range(0, SECS_PER_HOUR);
                end
                send_request(clock_now / SECS_PER_DAY, (clock_now % SECS_PER_DAY) / SECS_PER_HOUR,
                             (clock_now % SECS_PER_HOUR) / 60, clock_now % 60, pick_status());
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset window of 60 s: edge of window, time going back, out-of-range fields
        send_request(1, 0, 0, 0, 200);
        send_request(1, 0, 0, 59, 500);
        send_request(1, 0, 1, 0, 599);
        send_request(1, 0, 1, 0, 600);
        send_request(1, 0, 0, 30, 499);
        send_request(0, 0, 0, 0, 0);
        send_request(31, 31, 63, 63, 1023);
        send_request(31, 31, 63, 63, 1000);
        send_request(31, 23, 59, 59, 999);
        send_request(0, 31, 0, 63, 512);
        send_request(16, 16, 32, 32, 256);
        send_request(21, 10, 42, 21, 768);
        send_request(10, 5, 21, 42, 550);
        send_request(31, 23, 59, 59, 100);

        set_window(22'd1);
        run_phase(15, 2, 10);
        set_window(22'd0);
        run_phase(15, 1, 10);
        set_window(22'd3600);
        run_phase(25, 120, 10);
        // a full-scale window never trims; with the 32-day window after it the ring fills and overflows
        set_window(22'h3FFFFF);
        run_phase(700, 3, 20);
        set_window(22'd2764800);
        run_phase(350, 3, 2);
        set_window(22'd5);
        run_phase(20, 8, 10);
        set_window(22'd86400);
        run_phase(15, 7200, 10);
        set_window(22'd60);
        run_phase(15, 30, 10);

        wait_idle();
        $display("Covered %0d requests over %0d window settings, zero and full scale included",
                 requests_sent, settings_used);
        $display("Ring overflows %0d, peak window count %0d, mismatches %0d",
                 overflows, peak_seen, fail_count);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/swpr_pkg.sv
rtl/swpr_ram.sv
rtl/swpr_stamp.sv
rtl/swpr_ctrl.sv
rtl/sliding_window_peak_rate.sv
tb/sv/swpr_window_monitor.sv
tb/sv/sliding_window_peak_rate_test.sv
